// ----- design/mme_pkg.sv -----
`default_nettype none

package mme_pkg;

    // Default operand width
    localparam int WORD_BITS_DEF = 32;

    // Fixed width of the external data ports
    localparam int PORT_BITS = 32;

    // Register file decode (word index taken from paddr[2])
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_EXP  = 1'b1;

    // Register reset values
    localparam logic [PORT_BITS-1:0] BASE_RST = 32'd2;
    localparam logic [PORT_BITS-1:0] EXP_RST  = 32'd1;

    // Exponentiation sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED,
        ST_MUL,
        ST_SQR
    } t_state;

endpackage

`default_nettype wire

// ----- design/modular_exponentiation_top.sv -----
// Channel  | Signals                                        | Handshake
// ---------+------------------------------------------------+-------------------------------
// input    | start, busy, i_modulus[31:0]                   | transfer when start && !busy
// result   | o_valid, o_remainder[31:0]                     | one-cycle strobe, no backpressure
// config   | psel, penable, pwrite, paddr[2:0], pwdata,     | write on psel&penable&pwrite;
//          | prdata, pready                                 | base at 0x0, exponent at 0x4
//
// One item runs through a single bit-serial modular multiplier, one multiplication
// at a time. An item costs one base reduction, one multiply per set exponent bit
// and one squaring per exponent bit below the top. A zero modulus answers on the
// next cycle.
// Reset is synchronous and active low; busy stays high until the result strobe.
`default_nettype none

module modular_exponentiation_top
    import mme_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [PORT_BITS-1:0] i_modulus,
    output logic                      o_valid,
    output logic      [PORT_BITS-1:0] o_remainder,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [PORT_BITS-1:0] pwdata,
    output logic      [PORT_BITS-1:0] prdata,
    output logic                      pready
);

    localparam int IDX_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] cfg_base;
    logic [WORD_BITS-1:0] cfg_exponent;
    logic [WORD_BITS-1:0] mod_in;

    t_state               r_state, n_state;
    logic                 r_go, n_go;
    logic                 r_vld, n_vld;
    logic [WORD_BITS-1:0] r_res, n_res;
    logic [WORD_BITS-1:0] r_mod, n_mod;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_sq, n_sq;
    logic [WORD_BITS-1:0] r_exp, n_exp;
    logic [IDX_W-1:0]     r_idx, n_idx;

    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_prod;
    logic [WORD_BITS-1:0] op_a;
    logic [WORD_BITS-1:0] op_b;
    logic                 last_bit;
    logic                 next_last;

    mme_apb_regs #(
        .WORD_BITS (WORD_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_base     (cfg_base),
        .o_exponent (cfg_exponent)
    );

    mme_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_go),
        .i_mult_a  (op_a),
        .i_mult_b  (op_b),
        .i_mod     (r_mod),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    assign mod_in    = i_modulus[WORD_BITS-1:0];
    assign last_bit  = (r_idx == IDX_W'(WORD_BITS - 1));
    assign next_last = (r_idx == IDX_W'(WORD_BITS - 2));

    // Select multiplier operands by phase
    always_comb begin
        case (r_state)
            ST_RED: begin
                op_a = r_acc;
                op_b = cfg_base;
            end
            ST_MUL: begin
                op_a = r_acc;
                op_b = r_sq;
            end
            default: begin
                op_a = r_sq;
                op_b = r_sq;
            end
        endcase
    end

    // Sequence: reduce base, then multiply / square per exponent bit
    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_vld   = 1'b0;
        n_res   = r_res;
        n_mod   = r_mod;
        n_acc   = r_acc;
        n_sq    = r_sq;
        n_exp   = r_exp;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mod = mod_in;
                    n_exp = cfg_exponent;
                    n_idx = '0;
                    if (mod_in == '0) begin
                        n_vld = 1'b1;
                        n_res = '0;
                    end else begin
                        n_acc   = (mod_in == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                        n_state = ST_RED;
                        n_go    = 1'b1;
                    end
                end
            end
            ST_RED: begin
                if (mul_done) begin
                    n_sq = mul_prod;
                    if (r_exp[0]) begin
                        n_state = ST_MUL;
                        n_go    = 1'b1;
                    end else if (!last_bit) begin
                        n_state = ST_SQR;
                        n_go    = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                        n_vld   = 1'b1;
                        n_res   = r_acc;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_acc = mul_prod;
                    if (!last_bit) begin
                        n_state = ST_SQR;
                        n_go    = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                        n_vld   = 1'b1;
                        n_res   = mul_prod;
                    end
                end
            end
            ST_SQR: begin
                if (mul_done) begin
                    n_sq  = mul_prod;
                    n_exp = r_exp >> 1;
                    n_idx = r_idx + IDX_W'(1);
                    if (r_exp[1]) begin
                        n_state = ST_MUL;
                        n_go    = 1'b1;
                    end else if (!next_last) begin
                        n_state = ST_SQR;
                        n_go    = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                        n_vld   = 1'b1;
                        n_res   = r_acc;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go    <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_vld   <= n_vld;
        end
    end

    // Working values
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_mod <= n_mod;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_exp <= n_exp;
        r_idx <= n_idx;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_vld;
    assign o_remainder = PORT_BITS'(r_res);

endmodule

`default_nettype wire

// ----- design/mme_apb_regs.sv -----
`default_nettype none

module mme_apb_regs
    import mme_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [PORT_BITS-1:0] pwdata,
    output logic      [PORT_BITS-1:0] prdata,
    output logic                      pready,
    output logic      [WORD_BITS-1:0] o_base,
    output logic      [WORD_BITS-1:0] o_exponent
);

    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_exponent;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Capture register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_RST[WORD_BITS-1:0];
            r_exponent <= EXP_RST[WORD_BITS-1:0];
        end else if (wr_en) begin
            case (paddr[2])
                REG_BASE: r_base     <= pwdata[WORD_BITS-1:0];
                REG_EXP:  r_exponent <= pwdata[WORD_BITS-1:0];
                default:  ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            REG_BASE: prdata = PORT_BITS'(r_base);
            REG_EXP:  prdata = PORT_BITS'(r_exponent);
            default:  prdata = '0;
        endcase
    end

    assign o_base     = r_base;
    assign o_exponent = r_exponent;

endmodule

`default_nettype wire

// ----- design/mme_mulmod.sv -----
`default_nettype none

// Bit-serial interleaved modular multiplier: product = a * b mod m.
// Scans b from its top bit, one bit per cycle; requires a < m.
module mme_mulmod
    import mme_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_mult_a,
    input  wire logic [WORD_BITS-1:0] i_mult_b,
    input  wire logic [WORD_BITS-1:0] i_mod,
    output logic                      o_done,
    output logic      [WORD_BITS-1:0] o_product
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic                 r_run;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_acc;

    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   dbl_sub;
    logic [WORD_BITS-1:0] dbl_red;
    logic [WORD_BITS-1:0] addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_sub;
    logic [WORD_BITS-1:0] n_acc;

    // One step: double and reduce, then add the selected partial and reduce
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_sub = dbl - {1'b0, i_mod};
        dbl_red = (dbl >= {1'b0, i_mod}) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
        addend  = r_b[WORD_BITS-1] ? r_a : '0;
        sum     = {1'b0, dbl_red} + {1'b0, addend};
        sum_sub = sum - {1'b0, i_mod};
        n_acc   = (sum >= {1'b0, i_mod}) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(WORD_BITS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand latch, multiplier shift register and partial result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mult_a;
            r_b   <= i_mult_b;
            r_acc <= '0;
        end else if (r_run) begin
            r_b   <= {r_b[WORD_BITS-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// ----- design/mme_checker.sv -----
`default_nettype none

module mme_checker
    import mme_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic [PORT_BITS-1:0] i_modulus,
    input wire logic                 o_valid,
    input wire logic [PORT_BITS-1:0] o_remainder
);

    logic take;
    logic mod_zero;

    assign take     = start && !busy;
    assign mod_zero = (i_modulus[WORD_BITS-1:0] == '0);

    // A nonzero modulus starts a computation
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !mod_zero) |=> busy)
        else $error("nonzero modulus did not start a computation");

    // A zero modulus answers zero on the next cycle
    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && mod_zero) |=> (o_valid && o_remainder == '0 && !busy))
        else $error("zero modulus did not answer zero at once");

    // End of a computation delivers its result
    a_fall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("computation ended without a result strobe");

    // No result strobe while a computation runs
    a_busy_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result strobe while busy");

endmodule

bind modular_exponentiation_top mme_checker #(
    .WORD_BITS (WORD_BITS)
) u_mme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_modulus   (i_modulus),
    .o_valid     (o_valid),
    .o_remainder (o_remainder)
);

`default_nettype wire
